### src/spmfifo_pkg.sv
// Package for the strict priority multi-level task queue.
// Sizes, derived widths, status and register codes, sequencer states.
// No dependencies.
package spmfifo_pkg;

   localparam int LEVELS        = 4;
   localparam int LEVEL_DEPTH   = 16;
   localparam int HANDLE_WIDTH  = 32;

   localparam int STORE_SIZE    = LEVELS * LEVEL_DEPTH;
   localparam int LEVEL_W       = $clog2(LEVELS);
   localparam int PTR_W         = $clog2(LEVEL_DEPTH);
   localparam int ADDR_W        = $clog2(STORE_SIZE);
   localparam int FILL_W        = $clog2(LEVEL_DEPTH + 1);
   localparam int CNT_W         = $clog2(STORE_SIZE + 1);

   localparam int CAP_W         = 7;
   localparam int CMP_W         = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CAP_RESET     = 64;

   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int PRIO_W        = 3;
   localparam int IN_HANDLE_W   = 32;
   localparam int STATUS_W      = 3;
   localparam int OUT_LEVEL_W   = 2;
   localparam int TOTAL_W       = 7;
   localparam int LEVEL_COUNT_W = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHUT_DOWN  = 3'd1,
      STATUS_TOTAL_FULL = 3'd2,
      STATUS_LEVEL_FULL = 3'd3,
      STATUS_EMPTY      = 3'd4
   } status_type;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_DEQUEUE = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOTAL_CAPACITY = 1'b0,
      CSR_SHUT_DOWN      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_LEVEL,
      ST_WRITE,
      ST_SCAN,
      ST_READ,
      ST_COUNT,
      ST_RESP
   } fsm_state_type;

endpackage

### src/strict_priority_multi_fifo_top.sv
// Strict priority multi-level task queue: one handle FIFO per level in a shared store.
// A small sequencer drives one shared comparator and one store port.
// Depends on spmfifo_pkg.
//
// One beat in, one beat out. A stored enqueue goes through total check, level check,
// store write, count update and result; one refused at the total or the level check
// skips to the count update. A dequeue scans the levels one at a time from the top
// down, since every check goes through the one shared comparator, then reads the store
// if a level holds a handle, updates the count and gives the result. The block takes no
// new request until the result beat has been taken. Configuration writes are taken at
// any time and reach a request still in flight; make them only while the block is idle.
module strict_priority_multi_fifo_top
   import spmfifo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [PRIO_W-1:0]        req_priority_req,
   input  logic [IN_HANDLE_W-1:0]   req_task_handle,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [IN_HANDLE_W-1:0]   rsp_out_handle,
   output logic [OUT_LEVEL_W-1:0]   rsp_out_level,
   output logic [TOTAL_W-1:0]       rsp_total_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   output logic [LEVEL_COUNT_W-1:0] rsp_level_count,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   fsm_state_type            state_ff, state_in;

   logic [CAP_W-1:0]         cap_ff;
   logic                     shut_ff;

   logic [PTR_W-1:0]         head_ff [LEVELS];
   logic [PTR_W-1:0]         head_in [LEVELS];
   logic [PTR_W-1:0]         tail_ff [LEVELS];
   logic [PTR_W-1:0]         tail_in [LEVELS];
   logic [FILL_W-1:0]        fill_ff [LEVELS];
   logic [FILL_W-1:0]        fill_in [LEVELS];
   logic [CNT_W-1:0]         total_ff, total_in;

   logic [LEVEL_W-1:0]       lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]       scan_ff, scan_in;
   logic [HANDLE_WIDTH-1:0]  handle_ff, handle_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [LEVEL_W-1:0]       out_level_ff, out_level_in;
   logic                     hit_ff, hit_in;
   logic [FILL_W-1:0]        level_count_ff, level_count_in;
   logic                     is_full_ff, is_full_in;

   logic [HANDLE_WIDTH-1:0]  task_store [STORE_SIZE];
   logic [HANDLE_WIDTH-1:0]  rd_data_ff;
   logic                     mem_we;
   logic                     mem_re;
   logic [ADDR_W-1:0]        mem_addr;

   logic [LEVEL_W-1:0]       sel_lvl;
   logic [FILL_W-1:0]        fill_rd;
   logic [PTR_W-1:0]         ptr_rd;
   logic [PTR_W-1:0]         ptr_next;
   logic                     fill_at_depth;
   logic [CMP_W-1:0]         eff_cap;
   logic [CMP_W-1:0]         cmp_a;
   logic [CMP_W-1:0]         cmp_b;
   logic                     cmp_ge;
   logic [LEVEL_W-1:0]       req_lvl;
   logic                     req_beat;

   assign req_beat  = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign csr_ready = 1'b1;

   // map out-of-range priorities to the lowest level
   always_comb begin
      if (int'(req_priority_req) >= LEVELS) begin
         req_lvl = '0;
      end else begin
         req_lvl = LEVEL_W'(req_priority_req);
      end
   end

   always_comb begin
      if (CMP_W'(cap_ff) > CMP_W'(STORE_SIZE)) begin
         eff_cap = CMP_W'(STORE_SIZE);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign sel_lvl       = ((state_ff == ST_SCAN) || (state_ff == ST_READ)) ? scan_ff : lvl_ff;
   assign fill_rd       = fill_ff[sel_lvl];
   assign ptr_rd        = (state_ff == ST_WRITE) ? tail_ff[lvl_ff] : head_ff[scan_ff];
   assign ptr_next      = (ptr_rd == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr_rd + 1'b1;
   assign fill_at_depth = (int'(fill_rd) >= LEVEL_DEPTH);
   assign mem_addr      = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr_rd);

   // shared comparator; level cap check uses fill * LEVELS >= capacity
   always_comb begin
      cmp_a = CMP_W'(total_ff);
      cmp_b = eff_cap;
      case (state_ff)
         ST_LEVEL: begin
            cmp_a = CMP_W'(fill_rd) * CMP_W'(LEVELS);
            cmp_b = eff_cap;
         end
         ST_SCAN: begin
            cmp_a = CMP_W'(fill_rd);
            cmp_b = CMP_W'(1);
         end
         default: begin
            cmp_a = CMP_W'(total_ff);
            cmp_b = eff_cap;
         end
      endcase
   end

   assign cmp_ge = (cmp_a >= cmp_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = (req_mode == MODE_DEQUEUE) ? ST_SCAN : ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            state_in = (shut_ff || cmp_ge) ? ST_COUNT : ST_LEVEL;
         end
         ST_LEVEL: begin
            state_in = (cmp_ge || fill_at_depth) ? ST_COUNT : ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_COUNT;
         end
         ST_SCAN: begin
            if (cmp_ge) begin
               state_in = ST_READ;
            end else if (scan_ff == '0) begin
               state_in = ST_COUNT;
            end
         end
         ST_READ: begin
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      total_in       = total_ff;
      lvl_in         = lvl_ff;
      scan_in        = scan_ff;
      handle_in      = handle_ff;
      status_in      = status_ff;
      out_level_in   = out_level_ff;
      hit_in         = hit_ff;
      level_count_in = level_count_ff;
      is_full_in     = is_full_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               lvl_in       = req_lvl;
               scan_in      = LEVEL_W'(LEVELS - 1);
               handle_in    = HANDLE_WIDTH'(req_task_handle);
               status_in    = STATUS_OK;
               out_level_in = '0;
               hit_in       = 1'b0;
            end
         end
         ST_TOTAL: begin
            if (shut_ff) begin
               status_in = STATUS_SHUT_DOWN;
            end else if (cmp_ge) begin
               status_in = STATUS_TOTAL_FULL;
            end
         end
         ST_LEVEL: begin
            if (cmp_ge || fill_at_depth) begin
               status_in = STATUS_LEVEL_FULL;
            end
         end
         ST_WRITE: begin
            mem_we          = 1'b1;
            tail_in[lvl_ff] = ptr_next;
            fill_in[lvl_ff] = fill_rd + 1'b1;
            total_in        = total_ff + 1'b1;
         end
         ST_SCAN: begin
            if (!cmp_ge) begin
               if (scan_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  scan_in = scan_ff - 1'b1;
               end
            end
         end
         ST_READ: begin
            mem_re           = 1'b1;
            head_in[scan_ff] = ptr_next;
            fill_in[scan_ff] = fill_rd - 1'b1;
            total_in         = total_ff - 1'b1;
            out_level_in     = scan_ff;
            hit_in           = 1'b1;
         end
         ST_COUNT: begin
            level_count_in = fill_rd;
            is_full_in     = cmp_ge;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_W'(CAP_RESET);
         shut_ff  <= 1'b0;
         total_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOTAL_CAPACITY) begin
               cap_ff <= CAP_W'(csr_data);
            end else begin
               shut_ff <= csr_data[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff         <= lvl_in;
      scan_ff        <= scan_in;
      handle_ff      <= handle_in;
      status_ff      <= status_in;
      out_level_ff   <= out_level_in;
      hit_ff         <= hit_in;
      level_count_ff <= level_count_in;
      is_full_ff     <= is_full_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_store[mem_addr] <= handle_ff;
      end
      if (mem_re) begin
         rd_data_ff <= task_store[mem_addr];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_handle  = hit_ff ? IN_HANDLE_W'(rd_data_ff) : '0;
   assign rsp_out_level   = OUT_LEVEL_W'(out_level_ff);
   assign rsp_total_count = TOTAL_W'(total_ff);
   assign rsp_is_empty    = (total_ff == '0);
   assign rsp_is_full     = is_full_ff;
   assign rsp_level_count = LEVEL_COUNT_W'(level_count_ff);

endmodule

### dv/strict_priority_multi_fifo_top_tb.sv
// Testbench for strict_priority_multi_fifo_top: directed and random enqueue/dequeue traffic,
// predicted by a behavioral mirror of the per-level FIFOs and checked beat by beat.
// Depends on spmfifo_pkg and the strict_priority_multi_fifo_top RTL.
`timescale 1ns / 100ps

module strict_priority_multi_fifo_top_tb;
   import spmfifo_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RECONFIG_SPAN = 130;
   localparam int BIAS_SPAN = 32;

   typedef struct {
      status_type                 status;
      logic [IN_HANDLE_W-1:0]     handle;
      logic [OUT_LEVEL_W-1:0]     level;
      logic [TOTAL_W-1:0]         total;
      logic                       is_empty;
      logic                       is_full;
      logic [LEVEL_COUNT_W-1:0]   level_count;
   } queue_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_mode = MODE_ENQUEUE;
   logic [PRIO_W-1:0]        req_priority_req = '0;
   logic [IN_HANDLE_W-1:0]   req_task_handle = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [IN_HANDLE_W-1:0]   rsp_out_handle;
   logic [OUT_LEVEL_W-1:0]   rsp_out_level;
   logic [TOTAL_W-1:0]       rsp_total_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic [LEVEL_COUNT_W-1:0] rsp_level_count;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = CSR_TOTAL_CAPACITY;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   logic [HANDLE_WIDTH-1:0]  mirror_store [LEVELS][LEVEL_DEPTH];
   int unsigned              mirror_head [LEVELS];
   int unsigned              mirror_tail [LEVELS];
   int unsigned              mirror_fill [LEVELS];
   int unsigned              cfg_capacity = CAP_RESET;
   bit                       cfg_shut_down = 1'b0;

   queue_result_type         pending_queue_results [$];
   int unsigned              send_idle_pct = 0;
   int unsigned              recv_idle_pct = 0;
   int unsigned              quiet_cycles = 0;
   int unsigned              mismatch_count = 0;
   int unsigned              request_count = 0;
   int unsigned              reply_count = 0;
   int unsigned              config_count = 0;
   int unsigned              status_tally [5];

   strict_priority_multi_fifo_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_priority_req(req_priority_req),
      .req_task_handle (req_task_handle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_out_level   (rsp_out_level),
      .rsp_total_count (rsp_total_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_level_count (rsp_level_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned queued_total();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < LEVELS; i++) sum += mirror_fill[i];
      return sum;
   endfunction

   function automatic queue_result_type apply_queue_request(mode_type mode,
                                                            logic [PRIO_W-1:0] prio,
                                                            logic [IN_HANDLE_W-1:0] handle);
      queue_result_type r;
      int unsigned   lvl;
      int unsigned   cap;
      int unsigned   lcap;
      int unsigned   total;
      bit            found;
      r.status = STATUS_OK;
      r.handle = '0;
      r.level = '0;
      lvl = (32'(prio) >= LEVELS) ? 0 : 32'(prio);
      cap = (cfg_capacity > STORE_SIZE) ? STORE_SIZE : cfg_capacity;
      lcap = (cap + LEVELS - 1) / LEVELS;
      if (lcap > LEVEL_DEPTH) lcap = LEVEL_DEPTH;
      if (mode == MODE_ENQUEUE) begin
         if (cfg_shut_down)
            r.status = STATUS_SHUT_DOWN;
         else if (queued_total() >= cap)
            r.status = STATUS_TOTAL_FULL;
         else if (mirror_fill[lvl] >= lcap)
            r.status = STATUS_LEVEL_FULL;
         else begin
            mirror_store[lvl][mirror_tail[lvl]] = handle[HANDLE_WIDTH-1:0];
            mirror_tail[lvl] = (mirror_tail[lvl] + 1) % LEVEL_DEPTH;
            mirror_fill[lvl]++;
         end
      end else begin
         r.status = STATUS_EMPTY;
         found = 1'b0;
         for (int i = LEVELS - 1; i >= 0; i--) begin
            if (!found && mirror_fill[i] > 0) begin
               found = 1'b1;
               r.handle = mirror_store[i][mirror_head[i]];
               r.level = i[OUT_LEVEL_W-1:0];
               mirror_head[i] = (mirror_head[i] + 1) % LEVEL_DEPTH;
               mirror_fill[i]--;
               r.status = STATUS_OK;
            end
         end
      end
      total = queued_total();
      r.total = total[TOTAL_W-1:0];
      r.is_empty = (total == 0);
      r.is_full = (total >= cap);
      r.level_count = mirror_fill[lvl][LEVEL_COUNT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         reply_count++;
         if (pending_queue_results.size() == 0) begin
            $display("%0t: result beat with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_queue_results.pop_front();
            status_tally[want.status]++;
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("out_handle", 32'(want.handle), 32'(rsp_out_handle));
            check_field("out_level", 32'(want.level), 32'(rsp_out_level));
            check_field("total_count", 32'(want.total), 32'(rsp_total_count));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
            check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
            check_field("level_count", 32'(want.level_count), 32'(rsp_level_count));
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("strict_priority_multi_fifo_top test failed");
         $finish;
      end
   end

   task automatic send_request(mode_type mode, logic [PRIO_W-1:0] prio,
                               logic [IN_HANDLE_W-1:0] handle);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_priority_req <= prio;
      req_task_handle <= handle;
      do @(posedge clock); while (!req_ready);
      pending_queue_results.push_back(apply_queue_request(mode, prio, handle));
      request_count++;
   endtask

   task automatic wait_for_results(int unsigned settle);
      req_valid <= 1'b0;
      while (pending_queue_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_config(logic [CSR_DATA_W-1:0] capacity, bit shut);
      wait_for_results(3);
      csr_valid <= 1'b1;
      csr_index <= CSR_TOTAL_CAPACITY;
      csr_data <= capacity;
      do @(posedge clock); while (!csr_ready);
      cfg_capacity = 32'(capacity);
      csr_index <= CSR_SHUT_DOWN;
      csr_data <= {{(CSR_DATA_W-1){1'b0}}, shut};
      do @(posedge clock); while (!csr_ready);
      cfg_shut_down = shut;
      csr_valid <= 1'b0;
      config_count++;
   endtask

   task automatic test_empty_and_order();
      send_request(MODE_DEQUEUE, 3'd3, 32'h0);
      send_request(MODE_ENQUEUE, 3'd0, 32'h0000_0000);
      send_request(MODE_ENQUEUE, 3'd3, 32'hFFFF_FFFF);
      send_request(MODE_ENQUEUE, 3'd7, 32'h1234_5678);
      send_request(MODE_ENQUEUE, 3'd2, 32'h5A5A_A5A5);
      repeat (5) send_request(MODE_DEQUEUE, 3'd6, 32'hFFFF_FFFF);
   endtask

   task automatic test_level_full();
      write_config(7'd4, 1'b0);
      send_request(MODE_ENQUEUE, 3'd1, 32'hA5A5_0001);
      send_request(MODE_ENQUEUE, 3'd1, 32'hA5A5_0002);
      send_request(MODE_ENQUEUE, 3'd4, 32'hA5A5_0003);
      send_request(MODE_ENQUEUE, 3'd0, 32'hA5A5_0004);
   endtask

   task automatic test_capacity_extremes();
      write_config(7'd1, 1'b0);
      send_request(MODE_ENQUEUE, 3'd3, 32'h0F0F_0F0F);
      send_request(MODE_DEQUEUE, 3'd1, 32'h0);
      send_request(MODE_ENQUEUE, 3'd2, 32'hF0F0_F0F0);
      write_config(7'd0, 1'b0);
      send_request(MODE_ENQUEUE, 3'd2, 32'h8000_0001);
      send_request(MODE_DEQUEUE, 3'd5, 32'h0);
      write_config(7'd127, 1'b0);
      send_request(MODE_ENQUEUE, 3'd3, 32'h7FFF_FFFE);
      send_request(MODE_DEQUEUE, 3'd3, 32'h0);
   endtask

   task automatic test_shut_down();
      write_config(7'd64, 1'b0);
      send_request(MODE_ENQUEUE, 3'd2, 32'hC3C3_3C3C);
      write_config(7'd64, 1'b1);
      send_request(MODE_ENQUEUE, 3'd1, 32'h3C3C_C3C3);
      send_request(MODE_DEQUEUE, 3'd2, 32'h0);
      write_config(7'd64, 1'b0);
   endtask

   task automatic pick_random_config();
      logic [CSR_DATA_W-1:0] capacity;
      case ($urandom_range(9))
         0: capacity = 7'd0;
         1: capacity = 7'd1;
         2: capacity = 7'd127;
         3, 4: capacity = 7'd64;
         5: capacity = CSR_DATA_W'($urandom_range(2, 16));
         default: capacity = CSR_DATA_W'($urandom_range(17, 127));
      endcase
      write_config(capacity, $urandom_range(9) == 0);
   endtask

   task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                      int unsigned recv_pct);
      int unsigned enqueue_pct;
      mode_type    mode;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      enqueue_pct = 50;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % RECONFIG_SPAN == 0) pick_random_config();
         if (i % BIAS_SPAN == 0) begin
            case ($urandom_range(3))
               0: enqueue_pct = 25;
               1: enqueue_pct = 50;
               2: enqueue_pct = 75;
               default: enqueue_pct = 90;
            endcase
         end
         mode = ($urandom_range(99) < enqueue_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
         send_request(mode, PRIO_W'($urandom_range(7)), $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < LEVELS; i++) begin
         mirror_head[i] = 0;
         mirror_tail[i] = 0;
         mirror_fill[i] = 0;
      end
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_order();
      test_level_full();
      test_capacity_extremes();
      test_shut_down();
      test_random_traffic(650, 29, 51);
      test_random_traffic(650, 51, 29);
      test_random_traffic(650, 0, 0);
      wait_for_results(12);
      $display("Covered %0d requests, %0d result beats, %0d register settings.",
               request_count, reply_count, config_count);
      $display("Status mix ok/shut/total-full/level-full/empty: %0d/%0d/%0d/%0d/%0d",
               status_tally[STATUS_OK], status_tally[STATUS_SHUT_DOWN],
               status_tally[STATUS_TOTAL_FULL], status_tally[STATUS_LEVEL_FULL],
               status_tally[STATUS_EMPTY]);
      if (mismatch_count == 0)
         $display("strict_priority_multi_fifo_top test passed");
      else
         $display("strict_priority_multi_fifo_top test failed");
      $finish;
   end

endmodule

### files.f
src/spmfifo_pkg.sv
src/strict_priority_multi_fifo_top.sv
dv/strict_priority_multi_fifo_top_tb.sv
